@@ hw/rtl/first_fit_segment_allocator_unit_defines.svh @@
// ----------------------------------------------------------------------------
// first_fit_segment_allocator_unit_defines
// assertion macros used by the allocator unit rtl
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_SEGMENT_ALLOCATOR_UNIT_DEFINES_SVH
`define FIRST_FIT_SEGMENT_ALLOCATOR_UNIT_DEFINES_SVH

// condition holds at every edge out of reset
`define FFSA_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// trigger implies check in the next cycle
`define FFSA_ASSERT_NEXT(lbl, trig, chk, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (chk)) else $error(msg);

`endif

@@ hw/rtl/ffsa_pkg.sv @@
// ----------------------------------------------------------------------------
// ffsa_pkg
// types and constants of the first-fit segment allocator
// ----------------------------------------------------------------------------
package ffsa_pkg;

	localparam int SEG_W  = 20;
	localparam int NEED_W = 21;
	localparam int POOL_W = 21;
	localparam int STS_W  = 2;

	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	typedef enum logic [STS_W-1:0] {
		STS_OK        = 2'd0,
		STS_NO_FIT    = 2'd1,
		STS_NOT_ALLOC = 2'd2,
		STS_FULL      = 2'd3
	} status_t;

	typedef struct packed {
		logic             mode;
		logic [SEG_W-1:0] req_size;
		logic [SEG_W-1:0] free_addr;
	} req_t;

	typedef struct packed {
		status_t          status;
		logic [SEG_W-1:0] addr;
	} rsp_t;

	typedef struct packed {
		logic             valid;
		logic             in_use;
		logic [SEG_W-1:0] payload;
		logic [SEG_W-1:0] len;
	} seg_t;

	typedef struct packed {
		seg_t seg;
		logic tok;
	} cell_link_t;

	typedef enum logic [2:0] {
		CMD_HOLD,
		CMD_INIT,
		CMD_START,
		CMD_ADV,
		CMD_SPLIT,
		CMD_MRG_NEXT,
		CMD_CLR_USE,
		CMD_MRG_PREV
	} cell_op_t;

	typedef struct packed {
		cell_op_t          op;
		logic              mode;
		logic [SEG_W-1:0]  req_size;
		logic [NEED_W-1:0] need;
		logic [SEG_W-1:0]  where;
		logic [SEG_W-1:0]  init_len;
	} cell_cmd_t;

	typedef struct packed {
		logic             tok;
		logic             match;
		logic             nfree;
		logic             pfree;
		logic [SEG_W-1:0] payload;
	} cell_stat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SPLIT,
		ST_FREE,
		ST_MERGE,
		ST_DONE
	} state_t;

endpackage

@@ hw/rtl/first_fit_segment_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// first_fit_segment_allocator_unit
// first-fit allocator over a byte arena, segment table kept in a row of cells
// steps: a scan token walks the table from entry 0, one cell per cycle; an
//   allocate that fits at entry k then splits it, a free that finds its segment
//   at entry k clears it and merges it with free neighbors, a full table or no
//   match ends in an error response, and the response waits while stalled
// requests: one at a time, up to MAX_SEGMENTS entries scanned for each
// reset: table holds one free segment over a 65536 byte arena, no response
// ----------------------------------------------------------------------------
`include "first_fit_segment_allocator_unit_defines.svh"

module first_fit_segment_allocator_unit import ffsa_pkg::*; #(
	parameter int MAX_SEGMENTS = 64,
	parameter int HEADER_BYTES = 16,
	parameter int ADDR_BITS    = 20
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  req_t              req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output rsp_t              rsp,
	input  logic              cfg_we,
	input  logic [POOL_W-1:0] cfg_wdata
);

	localparam int CW = $clog2(MAX_SEGMENTS + 1);
	localparam logic [POOL_W-1:0] POOL_MIN = POOL_W'(64);
	localparam logic [POOL_W-1:0] POOL_CAP = (ADDR_BITS < SEG_W) ?
		POOL_W'(64'(1) << ADDR_BITS) : POOL_W'(64'(1) << SEG_W);
	localparam logic [POOL_W-1:0] RESET_POOL = (POOL_CAP < POOL_W'(65536)) ?
		POOL_CAP : POOL_W'(65536);
	localparam logic [SEG_W-1:0] RESET_LEN = SEG_W'(RESET_POOL - POOL_W'(HEADER_BYTES));
	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_SEGMENTS);

	state_t            state_q, state_d;
	logic [CW-1:0]     cnt_q, cnt_d;
	logic [CW-1:0]     idx_q, idx_d;
	logic              mode_q;
	logic [SEG_W-1:0]  req_size_q;
	logic [SEG_W-1:0]  where_q;
	rsp_t              res_q, res_d;
	rsp_t              rsp_q;
	logic              rsp_valid_q;
	logic              load_rsp;
	logic              accept;
	logic [POOL_W-1:0] pool;
	cell_cmd_t         cmd;

	cell_link_t        links [MAX_SEGMENTS];
	cell_stat_t        stats [MAX_SEGMENTS];
	logic [MAX_SEGMENTS-1:0] tok_vec;
	logic              hit, nfree, pfree;
	logic [SEG_W-1:0]  pay_sel;

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// segment cells
	for (genvar i = 0; i < MAX_SEGMENTS; i++) begin : g_cell
		cell_link_t lft, rgt;
		if (i == 0) begin : g_first
			assign lft = '0;
		end else begin : g_mid
			assign lft = links[i-1];
		end
		if (i == MAX_SEGMENTS - 1) begin : g_last
			assign rgt = '0;
		end else begin : g_inner
			assign rgt = links[i+1];
		end
		ffsa_cell #(
			.HEADER_BYTES(HEADER_BYTES),
			.FIRST       (i == 0),
			.INIT_PAYLOAD((i == 0) ? SEG_W'(HEADER_BYTES) : '0),
			.INIT_LEN    ((i == 0) ? RESET_LEN : '0)
		) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.cmd   (cmd),
			.left  (lft),
			.right (rgt),
			.link  (links[i]),
			.stat  (stats[i])
		);
		assign tok_vec[i] = stats[i].tok;
	end

	always_comb begin
		hit     = 1'b0;
		nfree   = 1'b0;
		pfree   = 1'b0;
		pay_sel = '0;
		for (int i = 0; i < MAX_SEGMENTS; i++) begin
			hit     = hit | stats[i].match;
			nfree   = nfree | stats[i].nfree;
			pfree   = pfree | stats[i].pfree;
			pay_sel = pay_sel | stats[i].payload;
		end
	end

	// pool clamp on a configuration write
	always_comb begin
		pool = cfg_wdata;
		if (pool < POOL_MIN) begin
			pool = POOL_MIN;
		end
		if (pool > POOL_CAP) begin
			pool = POOL_CAP;
		end
	end

	always_comb begin
		state_d      = state_q;
		cnt_d        = cnt_q;
		idx_d        = idx_q;
		res_d        = res_q;
		load_rsp     = 1'b0;
		cmd.op       = CMD_HOLD;
		cmd.mode     = mode_q;
		cmd.req_size = req_size_q;
		cmd.need     = {1'b0, req_size_q} + NEED_W'(HEADER_BYTES);
		cmd.where    = where_q;
		cmd.init_len = SEG_W'(pool - POOL_W'(HEADER_BYTES));
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.op  = CMD_START;
					idx_d   = '0;
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (hit) begin
					if (mode_q == MODE_FREE) begin
						state_d = ST_FREE;
					end else if (cnt_q == CNT_MAX) begin
						res_d   = '{status: STS_FULL, addr: '0};
						state_d = ST_DONE;
					end else begin
						res_d   = '{status: STS_OK, addr: pay_sel};
						state_d = ST_SPLIT;
					end
				end else if (idx_q == cnt_q) begin
					res_d   = '{status: (mode_q == MODE_FREE) ? STS_NOT_ALLOC : STS_NO_FIT,
						addr: '0};
					state_d = ST_DONE;
				end else begin
					cmd.op = CMD_ADV;
					idx_d  = idx_q + CW'(1);
				end
			end
			ST_SPLIT: begin
				cmd.op  = CMD_SPLIT;
				cnt_d   = cnt_q + CW'(1);
				state_d = ST_DONE;
			end
			ST_FREE: begin
				if (nfree) begin
					cmd.op = CMD_MRG_NEXT;
					cnt_d  = cnt_q - CW'(1);
				end else begin
					cmd.op = CMD_CLR_USE;
				end
				res_d   = '{status: STS_OK, addr: '0};
				state_d = ST_MERGE;
			end
			ST_MERGE: begin
				if (pfree) begin
					cmd.op = CMD_MRG_PREV;
					cnt_d  = cnt_q - CW'(1);
				end
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!rsp_valid_q || !rsp_stall) begin
					load_rsp = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (cfg_we) begin
			cmd.op = CMD_INIT;
			cnt_d  = CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= CW'(1);
			idx_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			idx_q   <= idx_d;
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_d;
		if (accept) begin
			mode_q     <= req.mode;
			req_size_q <= req.req_size;
			where_q    <= req.free_addr;
		end
		if (load_rsp) begin
			rsp_q <= res_q;
		end
	end

	`FFSA_ASSERT(a_cnt_range, (cnt_q >= CW'(1)) && (cnt_q <= CNT_MAX), "segment count out of range")
	`FFSA_ASSERT(a_tok_onehot, $onehot0(tok_vec), "more than one scan token")
	`FFSA_ASSERT_NEXT(a_split_cnt, (state_q == ST_SPLIT) && !cfg_we, cnt_q == $past(cnt_q) + CW'(1), "split did not grow table")
	`FFSA_ASSERT(a_addr_zero, !rsp_valid || (rsp.status == STS_OK) || (rsp.addr == '0), "nonzero addr on error")

endmodule

@@ hw/rtl/ffsa_cell.sv @@
// ----------------------------------------------------------------------------
// ffsa_cell
// one segment table entry with scan token, shifts with its neighbors
// ----------------------------------------------------------------------------
module ffsa_cell import ffsa_pkg::*; #(
	parameter int               HEADER_BYTES = 16,
	parameter bit               FIRST        = 1'b0,
	parameter logic [SEG_W-1:0] INIT_PAYLOAD = '0,
	parameter logic [SEG_W-1:0] INIT_LEN     = '0
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cell_cmd_t  cmd,
	input  cell_link_t left,
	input  cell_link_t right,
	output cell_link_t link,
	output cell_stat_t stat
);

	localparam logic [SEG_W-1:0] HDR = SEG_W'(HEADER_BYTES);

	seg_t seg_q;
	logic tok_q;
	logic vis_q;
	logic crit;
	logic after;

	assign after = !vis_q && !tok_q;
	assign link  = '{seg: seg_q, tok: tok_q};

	always_comb begin
		if (cmd.mode == MODE_ALLOC) begin
			crit = !seg_q.in_use && ({1'b0, seg_q.len} > cmd.need);
		end else begin
			crit = seg_q.in_use && (seg_q.payload == cmd.where);
		end
		stat.tok     = tok_q;
		stat.match   = tok_q && seg_q.valid && crit;
		stat.nfree   = tok_q && right.seg.valid && !right.seg.in_use;
		stat.pfree   = tok_q && left.seg.valid && !left.seg.in_use;
		stat.payload = tok_q ? seg_q.payload : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q <= '{valid: FIRST, in_use: 1'b0, payload: INIT_PAYLOAD, len: INIT_LEN};
			tok_q <= 1'b0;
			vis_q <= 1'b0;
		end else begin
			unique case (cmd.op)
				CMD_INIT: begin
					seg_q <= '{valid: FIRST, in_use: 1'b0, payload: HDR, len: cmd.init_len};
					tok_q <= 1'b0;
					vis_q <= 1'b0;
				end
				CMD_START: begin
					tok_q <= FIRST;
					vis_q <= 1'b0;
				end
				CMD_ADV: begin
					tok_q <= left.tok;
					vis_q <= vis_q | tok_q;
				end
				CMD_SPLIT: begin
					if (tok_q) begin
						seg_q.in_use <= 1'b1;
						seg_q.len    <= cmd.req_size;
					end else if (left.tok) begin
						seg_q.valid   <= 1'b1;
						seg_q.in_use  <= 1'b0;
						seg_q.payload <= left.seg.payload + SEG_W'(cmd.need);
						seg_q.len     <= left.seg.len - SEG_W'(cmd.need);
					end else if (!vis_q) begin
						seg_q <= left.seg;
					end
				end
				CMD_MRG_NEXT: begin
					if (tok_q) begin
						seg_q.in_use <= 1'b0;
						seg_q.len    <= seg_q.len + HDR + right.seg.len;
					end else if (after) begin
						seg_q <= right.seg;
					end
				end
				CMD_CLR_USE: begin
					if (tok_q) begin
						seg_q.in_use <= 1'b0;
					end
				end
				CMD_MRG_PREV: begin
					if (right.tok) begin
						seg_q.len <= seg_q.len + HDR + right.seg.len;
					end else if (tok_q || after) begin
						seg_q <= right.seg;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule
